FILE: design/mrfc_pkg.sv
// Shared types and constants for the MPU region match and fault check block.
// Used by mrfc_cell, mrfc_classify and the top level; depends on nothing.
package mrfc_pkg;

	localparam int unsigned NUM_REGIONS_DEF = 8;
	localparam int unsigned HIT_W           = 4;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	localparam logic [HIT_W-1:0] DEFAULT_HIT       = 4'd8;
	localparam logic [4:0]       DEFAULT_SIZE_CODE = 5'd28;
	localparam logic [2:0]       DEFAULT_PERM      = 3'd3;
	localparam logic [7:0]       DEFAULT_XN_MAP    = 8'hE4;
	localparam logic [11:0]      PPB_PREFIX        = 12'hE00;
	localparam logic [2:0]       SYS_SPACE         = 3'd7;
	localparam logic [4:0]       SUBREGION_MIN     = 5'd7;
	localparam logic [4:0]       SIZE_CODE_ALL     = 5'd31;

	// PMSAv7 AP codes
	localparam logic [2:0] AP_NONE      = 3'd0;
	localparam logic [2:0] AP_PRIV_RW   = 3'd1;
	localparam logic [2:0] AP_USER_RO   = 3'd2;
	localparam logic [2:0] AP_FULL      = 3'd3;
	localparam logic [2:0] AP_RSVD      = 3'd4;
	localparam logic [2:0] AP_PRIV_RO   = 3'd5;
	localparam logic [2:0] AP_RO        = 3'd6;
	localparam logic [2:0] AP_RO_ALT    = 3'd7;

	typedef enum logic [3:0] {
		CAUSE_NULL          = 4'd0,
		CAUSE_STACK         = 4'd1,
		CAUSE_UNMAPPED      = 4'd2,
		CAUSE_NOEXEC        = 4'd3,
		CAUSE_UNPRIV_NOEXEC = 4'd4,
		CAUSE_BLOCKED       = 4'd5,
		CAUSE_UNPRIV_BLOCK  = 4'd6,
		CAUSE_READONLY      = 4'd7,
		CAUSE_UNPRIV_RO     = 4'd8,
		CAUSE_UNKNOWN       = 4'd9
	} cause_t;

	typedef enum logic [2:0] {
		REG_PROTECT_EN = 3'd0,
		REG_FALLBACK   = 3'd1,
		REG_STACK_LIM  = 3'd2,
		REG_STACK_SIZE = 3'd3,
		REG_NULL_LIM   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             valid;
		logic             func;
		logic [2:0]       region_index;
		logic [26:0]      region_base;
		logic [4:0]       region_size_code;
		logic [7:0]       region_subregion_off;
		logic [2:0]       region_perm;
		logic             region_no_exec;
		logic             region_on;
		logic [31:0]      address;
		logic             is_fetch;
		logic             is_privileged;
		logic             hit;
		logic [HIT_W-1:0] hit_region;
		logic [4:0]       hit_size_code;
		logic [2:0]       hit_perm;
		logic             hit_no_exec;
	} req_t;

	typedef struct packed {
		logic        protect_enable;
		logic        default_map_fallback;
		logic [31:0] stack_floor;
		logic [16:0] stack_guard_size;
		logic [31:0] null_guard_limit;
	} cfg_t;

	typedef struct packed {
		logic             mapped;
		logic [HIT_W-1:0] hit_region;
		logic [4:0]       hit_size_code;
		logic [2:0]       hit_perm;
		logic             hit_no_exec;
		cause_t           fault_cause;
	} result_t;

endpackage

FILE: design/mpu_region_match_and_fault_check_top.sv
// Top level of the MPU region match and fault check block: APB registers,
// the chain of region cells and the result register. Depends on mrfc_pkg,
// mrfc_cell and mrfc_classify.
//
// Requests pass through a chain of NUM_REGIONS cells, one region entry per
// cell, lowest region first, so a later match overrides an earlier one and
// the highest-numbered region wins. A new request is accepted every cycle
// unless the chain holds; a check result passes through the register of
// each cell in the chain and then the result register. Region writes travel
// the same chain and take effect in request order; they give no result.
// The whole chain holds while a result waits to be taken.
module mpu_region_match_and_fault_check_top #(
	parameter int unsigned NUM_REGIONS = mrfc_pkg::NUM_REGIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [2:0]  region_index,
	input  logic [26:0] region_base,
	input  logic [4:0]  region_size_code,
	input  logic [7:0]  region_subregion_off,
	input  logic [2:0]  region_perm,
	input  logic        region_no_exec,
	input  logic        region_on,
	input  logic [31:0] address,
	input  logic        is_fetch,
	input  logic        is_privileged,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        mapped,
	output logic [3:0]  hit_region,
	output logic [4:0]  hit_size_code,
	output logic [2:0]  hit_perm,
	output logic        hit_no_exec,
	output logic [3:0]  fault_cause
);
	import mrfc_pkg::*;

	cfg_t     cfg_q;
	req_t     chain [NUM_REGIONS+1];
	result_t  res;
	result_t  res_q;
	logic     out_valid_q;
	logic     adv;
	reg_idx_t widx;

	assign pready   = 1'b1;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign widx     = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protect_enable       <= 1'b0;
			cfg_q.default_map_fallback <= 1'b0;
			cfg_q.stack_floor          <= 32'd0;
			cfg_q.stack_guard_size     <= 17'd32;
			cfg_q.null_guard_limit     <= 32'h0010_0000;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_PROTECT_EN: cfg_q.protect_enable       <= pwdata[0];
				REG_FALLBACK:   cfg_q.default_map_fallback <= pwdata[0];
				REG_STACK_LIM:  cfg_q.stack_floor          <= pwdata;
				REG_STACK_SIZE: cfg_q.stack_guard_size     <= pwdata[16:0];
				REG_NULL_LIM:   cfg_q.null_guard_limit     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_PROTECT_EN: prdata = {31'b0, cfg_q.protect_enable};
			REG_FALLBACK:   prdata = {31'b0, cfg_q.default_map_fallback};
			REG_STACK_LIM:  prdata = cfg_q.stack_floor;
			REG_STACK_SIZE: prdata = {15'b0, cfg_q.stack_guard_size};
			REG_NULL_LIM:   prdata = cfg_q.null_guard_limit;
			default:        prdata = 32'b0;
		endcase
	end

	always_comb begin
		chain[0]                      = '0;
		chain[0].valid                = in_valid;
		chain[0].func                 = func;
		chain[0].region_index         = region_index;
		chain[0].region_base          = region_base;
		chain[0].region_size_code     = region_size_code;
		chain[0].region_subregion_off = region_subregion_off;
		chain[0].region_perm          = region_perm;
		chain[0].region_no_exec       = region_no_exec;
		chain[0].region_on            = region_on;
		chain[0].address              = address;
		chain[0].is_fetch             = is_fetch;
		chain[0].is_privileged        = is_privileged;
	end

	for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
		mrfc_cell #(.INDEX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.req_in  (chain[i]),
			.req_out (chain[i+1])
		);
	end

	mrfc_classify u_classify (
		.req (chain[NUM_REGIONS]),
		.cfg (cfg_q),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[NUM_REGIONS].valid && (chain[NUM_REGIONS].func == FUNC_CHECK);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign mapped        = res_q.mapped;
	assign hit_region    = res_q.hit_region;
	assign hit_size_code = res_q.hit_size_code;
	assign hit_perm      = res_q.hit_perm;
	assign hit_no_exec   = res_q.hit_no_exec;
	assign fault_cause   = res_q.fault_cause;

	a_unmapped_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapped |-> hit_region == 4'd0 && hit_size_code == 5'd0 &&
			hit_perm == 3'd0 && !hit_no_exec)
		else $error("unmapped result carries hit attributes");

	a_default_attrs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mapped && hit_region == DEFAULT_HIT |->
			hit_size_code == DEFAULT_SIZE_CODE && hit_perm == DEFAULT_PERM)
		else $error("default map hit with wrong attributes");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mapped && hit_region != DEFAULT_HIT |->
			32'(hit_region) < NUM_REGIONS)
		else $error("hit region outside region table");

	a_unmapped_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapped |-> fault_cause == CAUSE_NULL ||
			fault_cause == CAUSE_STACK || fault_cause == CAUSE_UNMAPPED)
		else $error("unmapped access given a permission fault");

endmodule

FILE: design/mrfc_cell.sv
// One region cell: holds one region entry, captures writes addressed to it and
// updates the running match of a passing check request. Depends on mrfc_pkg.
module mrfc_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  mrfc_pkg::req_t req_in,
	output mrfc_pkg::req_t req_out
);
	import mrfc_pkg::*;

	localparam logic [HIT_W-1:0] IDX = HIT_W'(INDEX);

	logic [26:0] base_q;
	logic [4:0]  size_q;
	logic [7:0]  sub_off_q;
	logic [2:0]  perm_q;
	logic        no_exec_q;
	logic        on_q;

	logic [5:0]  span;
	logic [5:0]  sub_sh;
	logic [31:0] mask;
	logic [31:0] shifted;
	logic [2:0]  sub_idx;
	logic        sub_off;
	logic        match;
	logic        wr_hit;
	req_t        req_nxt;

	always_comb begin
		span    = {1'b0, size_q} + 6'd1;
		sub_sh  = span - 6'd3;
		mask    = 32'hFFFF_FFFF << span;
		shifted = req_in.address >> sub_sh;
		sub_idx = shifted[2:0];
		sub_off = (size_q >= SUBREGION_MIN) && sub_off_q[sub_idx];
		match   = on_q && (((req_in.address ^ {base_q, 5'b0}) & mask) == 32'h0) && !sub_off;
		wr_hit  = req_in.valid && (req_in.func == FUNC_WRITE) &&
			({1'b0, req_in.region_index} == IDX);
		req_nxt = req_in;
		if (req_in.func == FUNC_CHECK && match) begin
			req_nxt.hit           = 1'b1;
			req_nxt.hit_region    = IDX;
			req_nxt.hit_size_code = size_q;
			req_nxt.hit_perm      = perm_q;
			req_nxt.hit_no_exec   = no_exec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			size_q    <= '0;
			sub_off_q <= '0;
			perm_q    <= '0;
			no_exec_q <= 1'b0;
			on_q      <= 1'b0;
		end else if (adv && wr_hit) begin
			base_q    <= req_in.region_base;
			size_q    <= req_in.region_size_code;
			sub_off_q <= req_in.region_subregion_off;
			perm_q    <= req_in.region_perm;
			no_exec_q <= req_in.region_no_exec;
			on_q      <= req_in.region_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_out <= '0;
		end else if (adv) begin
			req_out <= req_nxt;
		end
	end

endmodule

FILE: design/mrfc_classify.sv
// Final lookup resolution (default map, system-space XN) and fault ranking.
// Combinational; depends on mrfc_pkg.
module mrfc_classify (
	input  mrfc_pkg::req_t    req,
	input  mrfc_pkg::cfg_t    cfg,
	output mrfc_pkg::result_t res
);
	import mrfc_pkg::*;

	logic        ppb;
	logic        sys;
	logic        use_default;
	logic        blk, wblk, ublk, uwblk;
	logic [32:0] stack_end;
	logic        in_stack;

	always_comb begin
		ppb = req.address[31:20] == PPB_PREFIX;
		sys = req.address[31:29] == SYS_SPACE;
		use_default = !cfg.protect_enable || ppb ||
			(!req.hit && cfg.default_map_fallback);

		res = '0;
		if (use_default) begin
			res.mapped        = 1'b1;
			res.hit_region    = DEFAULT_HIT;
			res.hit_size_code = DEFAULT_SIZE_CODE;
			res.hit_perm      = DEFAULT_PERM;
			res.hit_no_exec   = DEFAULT_XN_MAP[req.address[31:29]];
		end else if (req.hit) begin
			res.mapped        = 1'b1;
			res.hit_region    = req.hit_region;
			res.hit_size_code = req.hit_size_code;
			res.hit_perm      = req.hit_perm;
			res.hit_no_exec   = req.hit_no_exec | sys;
		end

		blk = 1'b0; wblk = 1'b0; ublk = 1'b0; uwblk = 1'b0;
		case (res.hit_perm)
			AP_NONE:    begin blk = 1'b1; ublk = 1'b1; end
			AP_PRIV_RW: ublk = 1'b1;
			AP_USER_RO: uwblk = 1'b1;
			AP_PRIV_RO: begin wblk = 1'b1; ublk = 1'b1; end
			AP_RO, AP_RO_ALT: begin wblk = 1'b1; uwblk = 1'b1; end
			default: ;
		endcase

		stack_end = {1'b0, cfg.stack_floor} + {16'b0, cfg.stack_guard_size};
		in_stack  = (req.address >= cfg.stack_floor) && ({1'b0, req.address} < stack_end);

		if (req.address <= cfg.null_guard_limit)
			res.fault_cause = CAUSE_NULL;
		else if (in_stack)
			res.fault_cause = CAUSE_STACK;
		else if (!res.mapped)
			res.fault_cause = CAUSE_UNMAPPED;
		else if (req.is_fetch && (res.hit_no_exec || blk))
			res.fault_cause = CAUSE_NOEXEC;
		else if (req.is_fetch && ublk && !req.is_privileged)
			res.fault_cause = CAUSE_UNPRIV_NOEXEC;
		else if (blk)
			res.fault_cause = CAUSE_BLOCKED;
		else if (!req.is_privileged && ublk)
			res.fault_cause = CAUSE_UNPRIV_BLOCK;
		else if (wblk)
			res.fault_cause = CAUSE_READONLY;
		else if (!req.is_privileged && uwblk)
			res.fault_cause = CAUSE_UNPRIV_RO;
		else
			res.fault_cause = CAUSE_UNKNOWN;
	end

endmodule

FILE: sim/mpu_region_match_and_fault_check_top_tb.sv
// Self-checking testbench for mpu_region_match_and_fault_check_top: directed table, then
// random region writes and lookups across register settings, checked by an in-bench predictor.
// Depends on mrfc_pkg and the design sources only.
module mpu_region_match_and_fault_check_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrfc_pkg::*;

	localparam int NUM_RGN   = NUM_REGIONS_DEF;
	localparam int LAT       = NUM_RGN + 1;
	localparam int PHASES    = 8;
	localparam int PHASE_LEN = 244;
	localparam int HOLD_LEN  = 400;

	typedef struct {
		logic        func;
		logic [2:0]  idx;
		logic [26:0] base;
		logic [4:0]  size;
		logic [7:0]  srd;
		logic [2:0]  perm;
		logic        xn;
		logic        en;
		logic [31:0] addr;
		logic        fetch;
		logic        priv;
	} mpu_req_t;

	typedef struct packed {
		logic [26:0] base;
		logic [4:0]  size;
		logic [7:0]  srd;
		logic [2:0]  perm;
		logic        xn;
		logic        en;
	} rgn_entry_t;

	typedef enum {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    ridx;
		logic [31:0] val;
		mpu_req_t    rq;
		bit          typed;
		result_t     want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [2:0]  region_index = '0;
	logic [26:0] region_base = '0;
	logic [4:0]  region_size_code = '0;
	logic [7:0]  region_subregion_off = '0;
	logic [2:0]  region_perm = '0;
	logic        region_no_exec = 1'b0;
	logic        region_on = 1'b0;
	logic [31:0] address = '0;
	logic        is_fetch = 1'b0;
	logic        is_privileged = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        mapped;
	logic [3:0]  hit_region;
	logic [4:0]  hit_size_code;
	logic [2:0]  hit_perm;
	logic        hit_no_exec;
	logic [3:0]  fault_cause;

	rgn_entry_t rgn[NUM_RGN];
	cfg_t       cur_cfg;
	result_t    pending_lookups[$];
	dir_row_t   dir_tab[$];

	bit      tab_typed = 1'b0;
	result_t tab_want;
	bit      hold_req = 1'b0;
	int      burst_left = 0;
	int      n_err = 0;
	int      n_writes = 0;
	int      n_checks = 0;
	int      n_results = 0;
	int      n_cfg = 0;

	mpu_region_match_and_fault_check_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.func                (func),
		.region_index        (region_index),
		.region_base         (region_base),
		.region_size_code    (region_size_code),
		.region_subregion_off(region_subregion_off),
		.region_perm         (region_perm),
		.region_no_exec      (region_no_exec),
		.region_on           (region_on),
		.address             (address),
		.is_fetch            (is_fetch),
		.is_privileged       (is_privileged),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.mapped              (mapped),
		.hit_region          (hit_region),
		.hit_size_code       (hit_size_code),
		.hit_perm            (hit_perm),
		.hit_no_exec         (hit_no_exec),
		.fault_cause         (fault_cause)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic result_t predict_lookup(logic [31:0] a, logic fetch, logic priv);
		result_t     res;
		logic [31:0] mask;
		logic [31:0] base;
		logic [32:0] stk_end;
		int          s;
		int          sub;
		int          i;
		bit          found;
		bit          blk;
		bit          wblk;
		bit          ublk;
		bit          uwblk;
		res = '0;
		found = 1'b0;
		blk = 1'b0;
		wblk = 1'b0;
		ublk = 1'b0;
		uwblk = 1'b0;
		if (cur_cfg.protect_enable && a[31:20] != PPB_PREFIX) begin
			for (i = NUM_RGN - 1; i >= 0 && !found; i--) begin
				if (rgn[i].en) begin
					s = rgn[i].size + 1;
					mask = (s < 32) ? ~((32'd1 << s) - 32'd1) : 32'd0;
					base = {rgn[i].base, 5'b0};
					sub = (s >= 8) ? ((a >> (s - 3)) & 7) : 0;
					if ((a & mask) == (base & mask) && (s < 8 || !rgn[i].srd[sub])) begin
						found = 1'b1;
						res.mapped = 1'b1;
						res.hit_region = 4'(i);
						res.hit_size_code = rgn[i].size;
						res.hit_perm = rgn[i].perm;
						res.hit_no_exec = rgn[i].xn | (a[31:29] == SYS_SPACE);
					end
				end
			end
		end
		if (!found && (!cur_cfg.protect_enable || a[31:20] == PPB_PREFIX ||
				cur_cfg.default_map_fallback)) begin
			res.mapped = 1'b1;
			res.hit_region = DEFAULT_HIT;
			res.hit_size_code = DEFAULT_SIZE_CODE;
			res.hit_perm = DEFAULT_PERM;
			res.hit_no_exec = DEFAULT_XN_MAP[a[31:29]];
		end
		case (res.hit_perm)
			AP_NONE: begin
				blk = 1'b1;
				ublk = 1'b1;
			end
			AP_PRIV_RW: ublk = 1'b1;
			AP_USER_RO: uwblk = 1'b1;
			AP_PRIV_RO: begin
				wblk = 1'b1;
				ublk = 1'b1;
			end
			AP_RO, AP_RO_ALT: begin
				wblk = 1'b1;
				uwblk = 1'b1;
			end
			default: ;
		endcase
		stk_end = {1'b0, cur_cfg.stack_floor} + {16'b0, cur_cfg.stack_guard_size};
		if (a <= cur_cfg.null_guard_limit)
			res.fault_cause = CAUSE_NULL;
		else if (a >= cur_cfg.stack_floor && {1'b0, a} < stk_end)
			res.fault_cause = CAUSE_STACK;
		else if (!res.mapped)
			res.fault_cause = CAUSE_UNMAPPED;
		else if (fetch && (res.hit_no_exec || blk))
			res.fault_cause = CAUSE_NOEXEC;
		else if (fetch && ublk && !priv)
			res.fault_cause = CAUSE_UNPRIV_NOEXEC;
		else if (blk)
			res.fault_cause = CAUSE_BLOCKED;
		else if (!priv && ublk)
			res.fault_cause = CAUSE_UNPRIV_BLOCK;
		else if (wblk)
			res.fault_cause = CAUSE_READONLY;
		else if (!priv && uwblk)
			res.fault_cause = CAUSE_UNPRIV_RO;
		else
			res.fault_cause = CAUSE_UNKNOWN;
		return res;
	endfunction

	function automatic mpu_req_t rand_req();
		mpu_req_t r;
		r.func = 1'($urandom);
		r.idx = 3'($urandom);
		r.base = 27'($urandom);
		r.size = 5'($urandom);
		r.srd = 8'($urandom);
		r.perm = 3'($urandom);
		r.xn = 1'($urandom);
		r.en = 1'($urandom);
		r.addr = $urandom;
		r.fetch = 1'($urandom);
		r.priv = 1'($urandom);
		return r;
	endfunction

	// addresses steered into regions, system space, the PPB, and the guard windows, or random
	function automatic logic [31:0] pick_addr();
		int          k;
		int          r;
		int          s;
		logic [31:0] span;
		k = $urandom_range(0, 99);
		r = $urandom_range(0, NUM_RGN - 1);
		s = rgn[r].size + 1;
		span = (s >= 32) ? 32'hFFFF_FFFF : ((32'd1 << s) - 32'd1);
		if (k < 55)
			return ({rgn[r].base, 5'b0} & ~span) | ($urandom & span);
		else if (k < 63)
			return {3'b111, 29'($urandom)};
		else if (k < 68)
			return {PPB_PREFIX, 20'($urandom)};
		else if (k < 77)
			return cur_cfg.stack_floor + $urandom_range(0, cur_cfg.stack_guard_size + 8) - 4;
		else if (k < 83)
			return cur_cfg.null_guard_limit + $urandom_range(0, 8) - 4;
		return $urandom;
	endfunction

	function automatic dir_row_t row_cfg(reg_idx_t idx, logic [31:0] val);
		dir_row_t d;
		d.kind = ROW_CFG;
		d.ridx = idx;
		d.val = val;
		d.rq = rand_req();
		d.typed = 1'b0;
		d.want = '0;
		return d;
	endfunction

	function automatic dir_row_t row_wr(logic [2:0] idx, logic [26:0] base, logic [4:0] size,
			logic [7:0] srd, logic [2:0] perm, logic xn, logic en);
		dir_row_t d;
		d = row_cfg(REG_PROTECT_EN, '0);
		d.kind = ROW_REQ;
		d.rq.func = FUNC_WRITE;
		d.rq.idx = idx;
		d.rq.base = base;
		d.rq.size = size;
		d.rq.srd = srd;
		d.rq.perm = perm;
		d.rq.xn = xn;
		d.rq.en = en;
		return d;
	endfunction

	function automatic dir_row_t row_chk(logic [31:0] a, logic fetch, logic priv);
		dir_row_t d;
		d = row_cfg(REG_PROTECT_EN, '0);
		d.kind = ROW_REQ;
		d.rq.func = FUNC_CHECK;
		d.rq.addr = a;
		d.rq.fetch = fetch;
		d.rq.priv = priv;
		return d;
	endfunction

	function automatic dir_row_t row_chk_exp(logic [31:0] a, logic fetch, logic priv,
			logic m, logic [3:0] hr, logic [4:0] hs, logic [2:0] hp, logic hx, cause_t c);
		dir_row_t d;
		d = row_chk(a, fetch, priv);
		d.typed = 1'b1;
		d.want.mapped = m;
		d.want.hit_region = hr;
		d.want.hit_size_code = hs;
		d.want.hit_perm = hp;
		d.want.hit_no_exec = hx;
		d.want.fault_cause = c;
		return d;
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PROTECT_EN: cur_cfg.protect_enable = val[0];
			REG_FALLBACK:   cur_cfg.default_map_fallback = val[0];
			REG_STACK_LIM:  cur_cfg.stack_floor = val;
			REG_STACK_SIZE: cur_cfg.stack_guard_size = val[16:0];
			REG_NULL_LIM:   cur_cfg.null_guard_limit = val;
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	// called in a rising-edge time step; returns at the edge that takes the request
	task automatic offer(mpu_req_t r);
		in_valid <= 1'b1;
		func <= r.func;
		region_index <= r.idx;
		region_base <= r.base;
		region_size_code <= r.size;
		region_subregion_off <= r.srd;
		region_perm <= r.perm;
		region_no_exec <= r.xn;
		region_on <= r.en;
		address <= r.addr;
		is_fetch <= r.fetch;
		is_privileged <= r.priv;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
	endtask

	// write requests give no result, so also wait out the pipeline
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endtask

	always @(negedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (func == FUNC_WRITE) begin
					n_writes++;
					if (region_index < NUM_RGN)
						rgn[region_index] = {region_base, region_size_code,
							region_subregion_off, region_perm, region_no_exec, region_on};
				end else begin
					n_checks++;
					if (tab_typed)
						pending_lookups.push_back(tab_want);
					else
						pending_lookups.push_back(predict_lookup(address, is_fetch,
							is_privileged));
				end
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (pending_lookups.size() == 0) begin
					$error("result with no lookup pending");
					n_err++;
				end else begin
					want = pending_lookups.pop_front();
					cmp_field("mapped", want.mapped, mapped);
					cmp_field("hit_region", want.hit_region, hit_region);
					cmp_field("hit_size_code", want.hit_size_code, hit_size_code);
					cmp_field("hit_perm", want.hit_perm, hit_perm);
					cmp_field("hit_no_exec", want.hit_no_exec, hit_no_exec);
					cmp_field("fault_cause", want.fault_cause, fault_cause);
				end
			end
		end
	end

	// receiver: changing stall patterns, plus a long hold-off on request
	initial begin
		int  mode;
		int  mode_left;
		int  hold_left;
		int  pat;
		bit  rdy;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		pat = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = HOLD_LEN;
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			pat++;
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom);
					2: rdy = (pat % 5) < 3;
					default: rdy = ($urandom_range(0, 7) != 0);
				endcase
			end
			out_ready <= rdy;
		end
	end

	initial begin
		int          k;
		int          ph;
		int          n;
		mpu_req_t    rq;
		logic        pe;
		logic        fb;
		logic [31:0] sl;
		logic [31:0] nl;
		logic [16:0] sg;
		for (k = 0; k < NUM_RGN; k++) rgn[k] = '0;
		cur_cfg.protect_enable = 1'b0;
		cur_cfg.default_map_fallback = 1'b0;
		cur_cfg.stack_floor = 32'd0;
		cur_cfg.stack_guard_size = 17'd32;
		cur_cfg.null_guard_limit = 32'd1048576;

		// reset settings: default map only
		dir_tab.push_back(row_chk_exp(32'h0000_0000, 1'b0, 1'b1,
			1'b1, DEFAULT_HIT, DEFAULT_SIZE_CODE, DEFAULT_PERM, 1'b0, CAUSE_NULL));
		dir_tab.push_back(row_chk_exp(32'hFFFF_FFFF, 1'b1, 1'b0,
			1'b1, DEFAULT_HIT, DEFAULT_SIZE_CODE, DEFAULT_PERM, 1'b1, CAUSE_NOEXEC));
		dir_tab.push_back(row_chk_exp(32'h0010_0001, 1'b1, 1'b0,
			1'b1, DEFAULT_HIT, DEFAULT_SIZE_CODE, DEFAULT_PERM, 1'b0, CAUSE_UNKNOWN));
		dir_tab.push_back(row_cfg(REG_PROTECT_EN, 32'd1));
		dir_tab.push_back(row_chk_exp(32'h2000_0000, 1'b0, 1'b1,
			1'b0, 4'd0, 5'd0, 3'd0, 1'b0, CAUSE_UNMAPPED));
		dir_tab.push_back(row_chk_exp(32'hE000_1000, 1'b0, 1'b0,
			1'b1, DEFAULT_HIT, DEFAULT_SIZE_CODE, DEFAULT_PERM, 1'b1, CAUSE_UNKNOWN));
		dir_tab.push_back(row_wr(3'd0, 27'h0, SIZE_CODE_ALL, 8'h00, AP_NONE, 1'b0, 1'b1));
		dir_tab.push_back(row_wr(3'd7, 27'h100_0000, 5'd11, 8'h02, AP_RO, 1'b1, 1'b1));
		dir_tab.push_back(row_wr(3'd3, 27'h180_0000, 5'd4, 8'hFF, AP_PRIV_RW, 1'b0, 1'b1));
		dir_tab.push_back(row_wr(3'd5, 27'h280_0000, 5'd27, 8'h00, AP_RSVD, 1'b0, 1'b1));
		dir_tab.push_back(row_wr(3'd6, 27'h300_0000, 5'd9, 8'h00, AP_USER_RO, 1'b0, 1'b1));
		dir_tab.push_back(row_wr(3'd4, 27'h380_0000, SUBREGION_MIN, 8'h80, AP_PRIV_RO,
			1'b0, 1'b1));
		dir_tab.push_back(row_wr(3'd2, 27'h7FF_FFFF, 5'd4, 8'hFF, AP_RO_ALT, 1'b1, 1'b0));
		dir_tab.push_back(row_chk(32'h2000_0000, 1'b0, 1'b0));
		dir_tab.push_back(row_chk(32'h2000_0200, 1'b0, 1'b0));
		dir_tab.push_back(row_chk(32'h3000_0010, 1'b1, 1'b0));
		dir_tab.push_back(row_chk(32'h3000_0010, 1'b0, 1'b0));
		dir_tab.push_back(row_chk(32'hF000_0000, 1'b0, 1'b1));
		dir_tab.push_back(row_chk(32'h5000_0004, 1'b1, 1'b0));
		dir_tab.push_back(row_chk(32'h6000_0100, 1'b0, 1'b0));
		dir_tab.push_back(row_chk(32'h7000_00F0, 1'b0, 1'b1));
		dir_tab.push_back(row_chk(32'h7000_0010, 1'b0, 1'b1));
		dir_tab.push_back(row_cfg(REG_FALLBACK, 32'd1));
		dir_tab.push_back(row_cfg(REG_STACK_LIM, 32'hFFFF_FFF0));
		dir_tab.push_back(row_cfg(REG_STACK_SIZE, 32'd65536));
		dir_tab.push_back(row_cfg(REG_NULL_LIM, 32'd0));
		dir_tab.push_back(row_wr(3'd0, 27'h0, 5'd0, 8'h00, AP_FULL, 1'b0, 1'b0));
		dir_tab.push_back(row_chk(32'h8000_0000, 1'b1, 1'b1));
		dir_tab.push_back(row_chk(32'hFFFF_FFFF, 1'b0, 1'b1));
		dir_tab.push_back(row_chk(32'h0000_0000, 1'b0, 1'b1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) begin
			if (dir_tab[k].kind == ROW_CFG) begin
				drain();
				apb_write(dir_tab[k].ridx, dir_tab[k].val);
			end else begin
				tab_typed = dir_tab[k].typed;
				tab_want = dir_tab[k].want;
				offer(dir_tab[k].rq);
				tab_typed = 1'b0;
				pace();
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					pe = 1'b1; fb = 1'b0; sl = $urandom; sg = 17'd32; nl = 32'h0010_0000;
				end
				1: begin
					pe = 1'b1; fb = 1'b1; sl = 32'hFFFF_FFFF; sg = 17'd65536; nl = 32'd0;
				end
				2: begin
					pe = 1'b0; fb = 1'b1; sl = $urandom; sg = 17'($urandom_range(32, 65536));
					nl = $urandom_range(0, 1 << 20);
				end
				3: begin
					pe = 1'b1; fb = 1'b0; sl = 32'd0; sg = 17'd0; nl = 32'hFFFF_FFFF;
				end
				default: begin
					pe = ($urandom_range(0, 3) != 0); fb = 1'($urandom); sl = $urandom;
					sg = 17'($urandom_range(32, 65536)); nl = $urandom_range(0, 1 << 24);
				end
			endcase
			apb_write(REG_PROTECT_EN, {31'b0, pe});
			apb_write(REG_FALLBACK, {31'b0, fb});
			apb_write(REG_STACK_LIM, sl);
			apb_write(REG_STACK_SIZE, {15'b0, sg});
			apb_write(REG_NULL_LIM, nl);
			for (n = 0; n < PHASE_LEN; n++) begin
				if (n == 40 && (ph == 1 || ph == 5))
					hold_req = 1'b1;
				if (n == 120 && ph == 2)
					drain();
				rq = rand_req();
				if ($urandom_range(0, 99) < 15) begin
					rq.func = FUNC_WRITE;
					rq.en = ($urandom_range(0, 4) != 0);
					if ($urandom_range(0, 2) == 0)
						rq.srd = 8'h00;
				end else begin
					rq.func = FUNC_CHECK;
					rq.addr = pick_addr();
				end
				offer(rq);
				pace();
			end
		end

		drain();
		repeat (2 * LAT) @(posedge clk);
		$display("Run covered %0d region writes and %0d lookups,", n_writes, n_checks);
		$display("%0d results compared, %0d register writes", n_results, n_cfg);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: mpu_region_match_and_fault_check_top.f
design/mrfc_pkg.sv
design/mrfc_cell.sv
design/mrfc_classify.sv
design/mpu_region_match_and_fault_check_top.sv
sim/mpu_region_match_and_fault_check_top_tb.sv
